// ===== hdl/irr_pkg.sv =====
// Shared types and constants of the ISO-TP receive reassembler.
// Used by the front end, the job queue, the back end and the top level.
`default_nettype none

package irr_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_FLOW  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // Error codes
  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_SEQUENCE   = 3'd1,
    ERR_FLOW       = 3'd2,
    ERR_UNEXPECTED = 3'd3,
    ERR_LENGTH     = 3'd4
  } err_e;

  // Frame types (upper nibble of the protocol control byte)
  localparam logic [3:0] FT_SINGLE = 4'h0;
  localparam logic [3:0] FT_FIRST  = 4'h1;
  localparam logic [3:0] FT_CONSEC = 4'h2;
  localparam logic [3:0] FT_FLOW   = 4'h3;

  localparam logic [3:0]  MAX_FLEN      = 4'd8;
  localparam logic [2:0]  MAX_CF_BYTES  = 3'd7;
  localparam logic [2:0]  FF_BYTES      = 3'd6;
  localparam logic [11:0] MIN_FF_LENGTH = 12'd8;
  localparam logic [11:0] CAP_RESET     = 12'd4095;

  // One classified frame, handed from the front end to the back end
  typedef struct packed {
    logic            is_err;
    err_e            err;
    logic            flow;     // follow the bytes with a flow-control request
    logic [2:0]      nbytes;   // payload bytes to emit
    logic [11:0]     base;     // offset of the first payload byte
    logic [11:0]     msg_len;  // message length, for the done mark
    logic [6:0][7:0] data;     // payload bytes, first one in entry 0
  } job_t;

endpackage

`default_nettype wire

// ===== hdl/irr_frame_if.sv =====
// Valid/ready channel carrying one received CAN frame per item.
// No dependencies.
`default_nettype none

interface irr_frame_if;
  logic       valid;
  logic       ready;
  logic [3:0] frame_length;
  logic [7:0] byte_zero;
  logic [7:0] byte_one;
  logic [7:0] byte_two;
  logic [7:0] byte_three;
  logic [7:0] byte_four;
  logic [7:0] byte_five;
  logic [7:0] byte_six;
  logic [7:0] byte_seven;

  modport source (
    output valid, frame_length, byte_zero, byte_one, byte_two, byte_three,
           byte_four, byte_five, byte_six, byte_seven,
    input  ready
  );

  modport sink (
    input  valid, frame_length, byte_zero, byte_one, byte_two, byte_three,
           byte_four, byte_five, byte_six, byte_seven,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/irr_result_if.sv =====
// Valid/ready channel carrying one reassembler result per item.
// No dependencies.
`default_nettype none

interface irr_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [11:0] byte_offset;
  logic [7:0]  byte_value;
  logic        message_done;
  logic [2:0]  error_code;
  logic        last;

  modport source (
    output valid, kind, byte_offset, byte_value, message_done, error_code, last,
    input  ready
  );

  modport sink (
    input  valid, kind, byte_offset, byte_value, message_done, error_code, last,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/isotp_receive_reassembler_top.sv =====
// Top level of the ISO-TP receive reassembler: front end, job queue, back end.
// Depends on irr_pkg, irr_frame_if, irr_result_if and the three submodules.
//
//   channel   dir  handshake        payload
//   frm_i     in   valid/ready      frame_length, byte_zero .. byte_seven
//   res_o     out  valid/ready      kind, byte_offset, byte_value, message_done,
//                                   error_code, last
//   cfg       in   cfg_we_i         cfg_wdata_i = buffer_capacity
//
// A frame is classified in the cycle it is accepted; a frame can be taken every
// cycle while the job queue has room. The back end emits one result per cycle when
// res_o takes it: 1 to 7 per frame, none when all bytes of a non-first frame drop.
// Reset clears the reception state and sets the capacity to 4095.
// Output stalls fill the queue, and only then is frm_i.ready dropped.
`default_nettype none

module isotp_receive_reassembler_top #(
  parameter int QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  irr_frame_if.sink        frm_i,
  irr_result_if.source     res_o,
  input  wire logic        cfg_we_i,
  input  wire logic [11:0] cfg_wdata_i
);

  irr_pkg::job_t push_job, head_job;
  logic          push, full, pop, empty;

  irr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frm_i       (frm_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .full_i      (full),
    .push_o      (push),
    .job_o       (push_job)
  );

  irr_job_fifo #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .job_o   (head_job),
    .empty_o (empty)
  );

  irr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .job_i   (head_job),
    .empty_i (empty),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule

`default_nettype wire

// ===== hdl/irr_front.sv =====
// Front end: accepts frames, tracks the reception state, classifies each frame
// into a job for the back end. Depends on irr_pkg and irr_frame_if.
`default_nettype none

module irr_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  irr_frame_if.sink         frm_i,
  input  wire logic         cfg_we_i,
  input  wire logic [11:0]  cfg_wdata_i,
  input  wire logic         full_i,
  output      logic         push_o,
  output      irr_pkg::job_t job_o
);

  logic        receiving_q, receiving_d;
  logic [11:0] msg_len_q, msg_len_d;
  logic [11:0] rcv_cnt_q, rcv_cnt_d;
  logic [3:0]  last_seq_q, last_seq_d;
  logic [11:0] cap_q;

  logic        accept;
  logic [3:0]  flen;
  logic [3:0]  ftype;
  logic [3:0]  nib;
  logic [11:0] ff_len;
  logic [11:0] remaining;
  logic [2:0]  take;
  logic [12:0] rcv_sum;
  logic [2:0]  nbytes_raw;
  logic [11:0] avail;
  logic [4:0]  nib_plus1;
  logic [3:0]  take_plus1;

  assign frm_i.ready = !full_i;
  assign accept      = frm_i.valid && !full_i;

  assign flen      = (frm_i.frame_length > irr_pkg::MAX_FLEN) ? irr_pkg::MAX_FLEN
                                                              : frm_i.frame_length;
  assign ftype     = frm_i.byte_zero[7:4];
  assign nib       = frm_i.byte_zero[3:0];
  assign ff_len    = {nib, frm_i.byte_one};
  assign nib_plus1 = {1'b0, nib} + 5'd1;
  assign remaining = (msg_len_q > rcv_cnt_q) ? (msg_len_q - rcv_cnt_q) : 12'd0;
  assign take      = (remaining < {9'd0, irr_pkg::MAX_CF_BYTES}) ? remaining[2:0]
                                                                 : irr_pkg::MAX_CF_BYTES;
  assign take_plus1 = {1'b0, take} + 4'd1;
  assign rcv_sum   = {1'b0, rcv_cnt_q} + {10'd0, take};

  always_comb begin
    receiving_d = receiving_q;
    msg_len_d   = msg_len_q;
    rcv_cnt_d   = rcv_cnt_q;
    last_seq_d  = last_seq_q;

    job_o.is_err  = 1'b0;
    job_o.err     = irr_pkg::ERR_NONE;
    job_o.flow    = 1'b0;
    job_o.base    = 12'd0;
    job_o.msg_len = msg_len_q;
    job_o.data    = {frm_i.byte_seven, frm_i.byte_six, frm_i.byte_five,
                     frm_i.byte_four, frm_i.byte_three, frm_i.byte_two,
                     frm_i.byte_one};
    nbytes_raw    = 3'd0;

    case (ftype)
      irr_pkg::FT_SINGLE: begin
        receiving_d = 1'b0;
        if (nib == 4'd0 || nib > 4'd7 || nib_plus1 > {1'b0, flen}) begin
          job_o.is_err = 1'b1;
          job_o.err    = irr_pkg::ERR_LENGTH;
        end else begin
          msg_len_d     = {8'd0, nib};
          rcv_cnt_d     = {8'd0, nib};
          job_o.msg_len = {8'd0, nib};
          nbytes_raw    = nib[2:0];
        end
      end
      irr_pkg::FT_FIRST: begin
        if (receiving_q) begin
          receiving_d  = 1'b0;
          job_o.is_err = 1'b1;
          job_o.err    = irr_pkg::ERR_UNEXPECTED;
        end else if (flen < irr_pkg::MAX_FLEN || ff_len < irr_pkg::MIN_FF_LENGTH) begin
          receiving_d  = 1'b0;
          job_o.is_err = 1'b1;
          job_o.err    = irr_pkg::ERR_LENGTH;
        end else begin
          msg_len_d     = ff_len;
          rcv_cnt_d     = {9'd0, irr_pkg::FF_BYTES};
          last_seq_d    = 4'd0;
          receiving_d   = 1'b1;
          job_o.msg_len = ff_len;
          job_o.flow    = 1'b1;
          job_o.data    = {8'd0, frm_i.byte_seven, frm_i.byte_six, frm_i.byte_five,
                           frm_i.byte_four, frm_i.byte_three, frm_i.byte_two};
          nbytes_raw    = irr_pkg::FF_BYTES;
        end
      end
      irr_pkg::FT_CONSEC: begin
        if (!receiving_q) begin
          job_o.is_err = 1'b1;
          job_o.err    = irr_pkg::ERR_UNEXPECTED;
        end else if (nib != (last_seq_q + 4'd1)) begin
          receiving_d  = 1'b0;
          job_o.is_err = 1'b1;
          job_o.err    = irr_pkg::ERR_SEQUENCE;
        end else if (take_plus1 > flen) begin
          receiving_d  = 1'b0;
          job_o.is_err = 1'b1;
          job_o.err    = irr_pkg::ERR_LENGTH;
        end else begin
          job_o.base = rcv_cnt_q;
          nbytes_raw = take;
          rcv_cnt_d  = rcv_sum[11:0];
          last_seq_d = nib;
          if (rcv_sum[11:0] >= msg_len_q) begin
            receiving_d = 1'b0;
          end
        end
      end
      irr_pkg::FT_FLOW: begin
        job_o.is_err = 1'b1;
        job_o.err    = irr_pkg::ERR_FLOW;
      end
      default: begin
        job_o.is_err = 1'b1;
        job_o.err    = irr_pkg::ERR_UNEXPECTED;
      end
    endcase

    // Offsets only grow within a frame, so the kept bytes form a prefix
    avail        = (cap_q > job_o.base) ? (cap_q - job_o.base) : 12'd0;
    job_o.nbytes = (avail < {9'd0, nbytes_raw}) ? avail[2:0] : nbytes_raw;
  end

  assign push_o = accept && (job_o.is_err || job_o.flow || (job_o.nbytes != 3'd0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receiving_q <= 1'b0;
      msg_len_q   <= 12'd0;
      rcv_cnt_q   <= 12'd0;
      last_seq_q  <= 4'd0;
      cap_q       <= irr_pkg::CAP_RESET;
    end else begin
      if (accept) begin
        receiving_q <= receiving_d;
        msg_len_q   <= msg_len_d;
        rcv_cnt_q   <= rcv_cnt_d;
        last_seq_q  <= last_seq_d;
      end
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/irr_job_fifo.sv =====
// Short job queue between the front end and the back end.
// Depends on irr_pkg.
`default_nettype none

module irr_job_fifo #(
  parameter int Depth = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire irr_pkg::job_t job_i,
  output      logic          full_o,
  input  wire logic          pop_i,
  output      irr_pkg::job_t job_o,
  output      logic          empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  irr_pkg::job_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt) else $error("job queue count out of range");

  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |=> $stable(wr_ptr_q)) else $error("job queue written while full");

  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |=> $stable(rd_ptr_q)) else $error("job queue read while empty");

endmodule

`default_nettype wire

// ===== hdl/irr_back.sv =====
// Back end: walks each job and emits its results one per cycle into an output
// register while it is free or taken. Depends on irr_pkg and irr_result_if.
`default_nettype none

module irr_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire irr_pkg::job_t job_i,
  input  wire logic          empty_i,
  output      logic          pop_o,
  irr_result_if.source       res_o
);

  logic           valid_q;
  logic [2:0]     idx_q;
  irr_pkg::kind_e kind_q, kind_d;
  logic [11:0]    offset_q, offset_d;
  logic [7:0]     value_q, value_d;
  logic           done_q, done_d;
  irr_pkg::err_e  err_q, err_d;
  logic           last_q, last_d;

  logic           step;
  logic [11:0]    byte_off;

  assign step     = (!valid_q || res_o.ready) && !empty_i;
  assign byte_off = job_i.base + {9'd0, idx_q};

  always_comb begin
    kind_d   = irr_pkg::KIND_BYTE;
    offset_d = 12'd0;
    value_d  = 8'd0;
    done_d   = 1'b0;
    err_d    = irr_pkg::ERR_NONE;
    last_d   = 1'b1;
    if (job_i.is_err) begin
      kind_d = irr_pkg::KIND_ERROR;
      err_d  = job_i.err;
    end else if (idx_q < job_i.nbytes) begin
      offset_d = byte_off;
      value_d  = job_i.data[idx_q];
      done_d   = ((byte_off + 12'd1) == job_i.msg_len);
      last_d   = (idx_q == (job_i.nbytes - 3'd1)) && !job_i.flow;
    end else begin
      kind_d = irr_pkg::KIND_FLOW;
    end
  end

  assign pop_o = step && last_d;

  always_ff @(posedge clk_i) begin
    if (step) begin
      kind_q   <= kind_d;
      offset_q <= offset_d;
      value_q  <= value_d;
      done_q   <= done_d;
      err_q    <= err_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 3'd0;
    end else begin
      if (step) begin
        valid_q <= 1'b1;
        idx_q   <= last_d ? 3'd0 : idx_q + 3'd1;
      end else if (res_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign res_o.valid        = valid_q;
  assign res_o.kind         = kind_q;
  assign res_o.byte_offset  = offset_q;
  assign res_o.byte_value   = value_q;
  assign res_o.message_done = done_q;
  assign res_o.error_code   = err_q;
  assign res_o.last         = last_q;

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (kind_q == irr_pkg::KIND_ERROR) |-> last_q && (err_q != irr_pkg::ERR_NONE))
    else $error("error result not closing its frame");

  a_flow_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (kind_q == irr_pkg::KIND_FLOW) |-> last_q && !done_q)
    else $error("flow-control request not closing its frame");

  a_done_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && done_q |-> (kind_q == irr_pkg::KIND_BYTE) && last_q)
    else $error("message done on a non-final result");

  a_idx_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (idx_q == 3'd0)) else $error("result index not rewound after a job");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for the ISO-TP receive reassembler: frames in, results checked one by one
// against a behavioral reassembler kept in this file. Depends on irr_pkg and the
// irr_frame_if / irr_result_if channels.
`timescale 1ns / 100ps

module tb_top;

  localparam int SETTLE_CYCLES  = 40;
  localparam int STALL_CYCLES   = 300;
  localparam int WATCHDOG_LIMIT = 3000;

  // Frame types with no meaning to the reassembler
  localparam logic [3:0] FT_RESERVED_LO = 4'h4;
  localparam logic [3:0] FT_RESERVED_HI = 4'hf;

  // Ways a multi-frame message gets broken
  localparam int FLAW_NONE     = 0;
  localparam int FLAW_SEQUENCE = 1;
  localparam int FLAW_SHORT    = 2;
  localparam int FLAW_FLOW     = 3;
  localparam int FLAW_RESTART  = 4;
  localparam int FLAW_OTHER    = 5;

  typedef struct packed {
    logic [3:0]      flen;
    logic [7:0][7:0] b;      // b[0] is the protocol control byte
  } can_frame_t;

  typedef struct packed {
    irr_pkg::kind_e kind;
    logic [11:0]    offset;
    logic [7:0]     value;
    logic           done;
    irr_pkg::err_e  err;
    logic           last;
  } rx_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [11:0] cfg_wdata;

  irr_frame_if  frm_if ();
  irr_result_if res_if ();

  isotp_receive_reassembler_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .frm_i       (frm_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Reassembler state as the block should hold it
  logic        rx_active = 1'b0;
  logic [11:0] msg_len   = '0;
  logic [11:0] rx_count  = '0;
  logic [3:0]  last_seq  = '0;
  logic [11:0] cap_model = irr_pkg::CAP_RESET;

  rx_result_t frame_results[$];
  rx_result_t due_results[$];

  int  mismatches   = 0;
  int  frames_sent  = 0;
  int  quiet_cycles = 0;
  int  src_idle_pct = 0;
  int  snk_idle_pct = 0;
  bit  stall_toggle = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 50) begin
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  function automatic void add_result(irr_pkg::kind_e k, int off, logic [7:0] val,
                                     logic done, irr_pkg::err_e e);
    rx_result_t r;
    r.kind   = k;
    r.offset = off[11:0];
    r.value  = val;
    r.done   = done;
    r.err    = e;
    r.last   = 1'b0;
    frame_results.push_back(r);
  endfunction

  function automatic void add_error(irr_pkg::err_e e);
    add_result(irr_pkg::KIND_ERROR, 0, 8'h00, 1'b0, e);
  endfunction

  function automatic void reassemble_frame(can_frame_t f);
    int          flen;
    int          nib;
    int          take;
    int          remaining;
    int          off_i;
    logic [11:0] len;
    rx_result_t  tail;
    frame_results.delete();
    flen = (f.flen > 4'd8) ? 8 : int'(f.flen);
    nib  = int'(f.b[0][3:0]);
    case (f.b[0][7:4])
      irr_pkg::FT_SINGLE: begin
        rx_active = 1'b0;
        if (nib == 0 || nib > 7 || nib + 1 > flen) begin
          add_error(irr_pkg::ERR_LENGTH);
        end else begin
          msg_len  = 12'(nib);
          rx_count = 12'(nib);
          for (int i = 0; i < nib; i++) begin
            if (i < int'(cap_model)) begin
              add_result(irr_pkg::KIND_BYTE, i, f.b[1+i], i + 1 == nib, irr_pkg::ERR_NONE);
            end
          end
        end
      end
      irr_pkg::FT_FIRST: begin
        len = {f.b[0][3:0], f.b[1]};
        if (rx_active) begin
          rx_active = 1'b0;
          add_error(irr_pkg::ERR_UNEXPECTED);
        end else if (flen < 8 || len < irr_pkg::MIN_FF_LENGTH) begin
          add_error(irr_pkg::ERR_LENGTH);
        end else begin
          msg_len   = len;
          rx_count  = 12'd6;
          last_seq  = 4'd0;
          rx_active = 1'b1;
          for (int i = 0; i < 6; i++) begin
            if (i < int'(cap_model)) begin
              add_result(irr_pkg::KIND_BYTE, i, f.b[2+i], 1'b0, irr_pkg::ERR_NONE);
            end
          end
          add_result(irr_pkg::KIND_FLOW, 0, 8'h00, 1'b0, irr_pkg::ERR_NONE);
        end
      end
      irr_pkg::FT_CONSEC: begin
        if (!rx_active) begin
          add_error(irr_pkg::ERR_UNEXPECTED);
        end else if (f.b[0][3:0] != last_seq + 4'd1) begin
          rx_active = 1'b0;
          add_error(irr_pkg::ERR_SEQUENCE);
        end else begin
          remaining = (msg_len > rx_count) ? int'(msg_len - rx_count) : 0;
          take = (remaining < 7) ? remaining : 7;
          if (take + 1 > flen) begin
            rx_active = 1'b0;
            add_error(irr_pkg::ERR_LENGTH);
          end else begin
            for (int i = 0; i < take; i++) begin
              off_i = int'(rx_count) + i;
              if (off_i < int'(cap_model)) begin
                add_result(irr_pkg::KIND_BYTE, off_i, f.b[1+i], off_i + 1 == int'(msg_len),
                           irr_pkg::ERR_NONE);
              end
            end
            rx_count = rx_count + 12'(take);
            last_seq = f.b[0][3:0];
            if (rx_count >= msg_len) rx_active = 1'b0;
          end
        end
      end
      irr_pkg::FT_FLOW: add_error(irr_pkg::ERR_FLOW);
      default: add_error(irr_pkg::ERR_UNEXPECTED);
    endcase
    if (frame_results.size() > 0) begin
      tail = frame_results.pop_back();
      tail.last = 1'b1;
      frame_results.push_back(tail);
    end
    foreach (frame_results[i]) due_results.push_back(frame_results[i]);
  endfunction

  // Monitor: predicts on accepted frames and config writes, checks accepted results
  always @(posedge clk) begin
    rx_result_t want;
    can_frame_t seen;
    if (rst_n) begin
      if (cfg_we) cap_model = cfg_wdata;
      if (frm_if.valid && frm_if.ready) begin
        seen.flen = frm_if.frame_length;
        seen.b = {frm_if.byte_seven, frm_if.byte_six, frm_if.byte_five, frm_if.byte_four,
                  frm_if.byte_three, frm_if.byte_two, frm_if.byte_one, frm_if.byte_zero};
        reassemble_frame(seen);
      end
      if (res_if.valid && res_if.ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("result with nothing due, kind", res_if.kind, -1);
        end else begin
          want = due_results.pop_front();
          if (res_if.kind !== want.kind)
            report_mismatch("kind", res_if.kind, want.kind);
          if (res_if.byte_offset !== want.offset)
            report_mismatch("byte_offset", res_if.byte_offset, want.offset);
          if (res_if.byte_value !== want.value)
            report_mismatch("byte_value", res_if.byte_value, want.value);
          if (res_if.message_done !== want.done)
            report_mismatch("message_done", res_if.message_done, want.done);
          if (res_if.error_code !== want.err)
            report_mismatch("error_code", res_if.error_code, want.err);
          if (res_if.last !== want.last)
            report_mismatch("last", res_if.last, want.last);
        end
      end
    end
    if ((frm_if.valid && frm_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: random back-pressure, plus a long hold-off on request
  always @(posedge clk) begin
    static bit stall_seen = 1'b0;
    static int hold_left  = 0;
    if (stall_toggle != stall_seen) begin
      stall_seen = stall_toggle;
      hold_left  = STALL_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  function automatic logic [3:0] roomy_length(int need);
    int pick;
    pick = $urandom_range(9);
    if (pick < 5) return 4'(need);
    if (pick < 8) return 4'($urandom_range(need, 8));
    return 4'($urandom_range(need, 15));
  endfunction

  function automatic can_frame_t make_frame(logic [3:0] flen, logic [7:0] b0);
    can_frame_t f;
    f.flen = flen;
    for (int i = 1; i < 8; i++) f.b[i] = 8'($urandom);
    f.b[0] = b0;
    return f;
  endfunction

  function automatic can_frame_t first_frame(logic [11:0] len);
    can_frame_t f;
    f = make_frame(roomy_length(8), {irr_pkg::FT_FIRST, len[11:8]});
    f.b[1] = len[7:0];
    return f;
  endfunction

  // Valid stays high from one item to the next unless a gap is taken
  task automatic send_frame(input can_frame_t f);
    if ($urandom_range(99) < src_idle_pct) begin
      frm_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    frm_if.valid        <= 1'b1;
    frm_if.frame_length <= f.flen;
    frm_if.byte_zero    <= f.b[0];
    frm_if.byte_one     <= f.b[1];
    frm_if.byte_two     <= f.b[2];
    frm_if.byte_three   <= f.b[3];
    frm_if.byte_four    <= f.b[4];
    frm_if.byte_five    <= f.b[5];
    frm_if.byte_six     <= f.b[6];
    frm_if.byte_seven   <= f.b[7];
    @(posedge clk);
    while (!frm_if.ready) @(posedge clk);
    frames_sent++;
  endtask

  task automatic send_single(input int nbytes);
    send_frame(make_frame(roomy_length(nbytes + 1), {irr_pkg::FT_SINGLE, 4'(nbytes)}));
  endtask

  // First frame plus consecutive frames; a flaw is placed at a random consecutive frame
  task automatic send_message(input int len, input int flaw);
    can_frame_t f;
    int         count;
    int         take;
    int         cf_total;
    int         bad_at;
    logic [3:0] seq;
    send_frame(first_frame(12'(len)));
    count    = 6;
    seq      = 4'd1;
    cf_total = (len - 6 + 6) / 7;
    bad_at   = (flaw != FLAW_NONE) ? $urandom_range(0, cf_total - 1) : -1;
    for (int k = 0; k < cf_total; k++) begin
      take = (len - count < 7) ? len - count : 7;
      if (k == bad_at) begin
        case (flaw)
          FLAW_SEQUENCE: begin
            send_frame(make_frame(4'd8,
                                  {irr_pkg::FT_CONSEC, seq + 4'($urandom_range(1, 15))}));
            return;
          end
          FLAW_SHORT: begin
            send_frame(make_frame(4'($urandom_range(0, take)), {irr_pkg::FT_CONSEC, seq}));
            return;
          end
          FLAW_RESTART: begin
            send_frame(first_frame(12'($urandom_range(8, 60))));
            return;
          end
          FLAW_FLOW: begin
            send_frame(make_frame(4'($urandom_range(0, 15)),
                                  {irr_pkg::FT_FLOW, 4'($urandom)}));
          end
          default: begin
            send_frame(make_frame(4'($urandom_range(0, 15)),
                                  {4'($urandom_range(FT_RESERVED_LO, FT_RESERVED_HI)),
                                   4'($urandom)}));
          end
        endcase
      end
      send_frame(make_frame(roomy_length(take + 1), {irr_pkg::FT_CONSEC, seq}));
      count += take;
      seq++;
    end
  endtask

  // Waits out all pending work, then writes the capacity
  task automatic write_capacity(input logic [11:0] cap);
    frm_if.valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic test_single_frames();
    can_frame_t f;
    f = make_frame(4'd8, {irr_pkg::FT_SINGLE, 4'd7});
    for (int i = 1; i < 8; i++) f.b[i] = 8'hff;
    send_frame(f);
    f = make_frame(4'd8, {irr_pkg::FT_SINGLE, 4'd7});
    for (int i = 1; i < 8; i++) f.b[i] = 8'h00;
    send_frame(f);
    send_frame(make_frame(4'd2, {irr_pkg::FT_SINGLE, 4'd1}));
    send_frame(make_frame(4'd15, {irr_pkg::FT_SINGLE, 4'd7}));  // over-long frame counts as eight
    send_frame(make_frame(4'd8, {irr_pkg::FT_SINGLE, 4'd0}));   // zero length
    send_frame(make_frame(4'd8, {irr_pkg::FT_SINGLE, 4'd8}));   // length above seven
    send_frame(make_frame(4'd8, {irr_pkg::FT_SINGLE, 4'hf}));
    send_frame(make_frame(4'd5, {irr_pkg::FT_SINGLE, 4'd5}));   // frame too short for its length
    send_frame(make_frame(4'd0, {irr_pkg::FT_SINGLE, 4'd1}));
  endtask

  task automatic test_frame_types();
    send_frame(make_frame(4'd8, {irr_pkg::FT_CONSEC, 4'd1}));   // consecutive frame while idle
    send_frame(make_frame(4'd3, {irr_pkg::FT_FLOW, 4'd0}));
    send_frame(make_frame(4'd8, {FT_RESERVED_LO, 4'd0}));
    send_frame(make_frame(4'd8, {FT_RESERVED_HI, 4'hf}));
  endtask

  task automatic test_first_frames();
    can_frame_t f;
    f = first_frame(12'd20);
    f.flen = 4'd7;
    send_frame(f);                                     // first frame not full
    send_frame(first_frame(12'd7));                    // message length below eight
    send_message(8, FLAW_NONE);
    send_message(20, FLAW_RESTART);
    send_message(20, FLAW_SEQUENCE);
    send_message(20, FLAW_SHORT);
    send_frame(first_frame(12'd13));
    send_single(4);                                    // single frame aborts the message
  endtask

  task automatic test_capacity();
    write_capacity(12'd0);
    send_single(7);                                    // everything dropped: no results
    send_message(10, FLAW_NONE);
    write_capacity(12'd10);
    send_message(20, FLAW_NONE);                       // tail dropped, no done mark
    send_single(7);
    write_capacity(12'd4095);
  endtask

  task automatic test_pressure();
    stall_toggle = ~stall_toggle;
    send_message(60, FLAW_NONE);
  endtask

  task automatic test_long_messages();
    send_message(300, FLAW_NONE);                      // sequence number wraps twice
    send_frame(first_frame(12'd4095));
    send_frame(make_frame(4'd8, {irr_pkg::FT_CONSEC, 4'd1}));
    send_single(3);
  endtask

  task automatic test_random(input int n_frames, input logic [11:0] cap);
    int stop_at;
    int pick;
    write_capacity(cap);
    stop_at = frames_sent + n_frames;
    while (frames_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        send_message(($urandom_range(9) == 0) ? $urandom_range(49, 200) : $urandom_range(8, 40),
                     FLAW_NONE);
      end else if (pick < 75) begin
        send_message($urandom_range(8, 40), $urandom_range(FLAW_SEQUENCE, FLAW_OTHER));
      end else if (pick < 88) begin
        send_single($urandom_range(1, 7));
      end else begin
        send_frame(make_frame(4'($urandom_range(0, 15)), 8'($urandom)));
      end
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    frm_if.valid        = 1'b0;
    frm_if.frame_length = '0;
    frm_if.byte_zero    = '0;
    frm_if.byte_one     = '0;
    frm_if.byte_two     = '0;
    frm_if.byte_three   = '0;
    frm_if.byte_four    = '0;
    frm_if.byte_five    = '0;
    frm_if.byte_six     = '0;
    frm_if.byte_seven   = '0;
    res_if.ready        = 1'b0;
    src_idle_pct        = 33;
    snk_idle_pct        = 85;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_frames();
    test_frame_types();
    test_first_frames();
    test_capacity();
    test_random(55, 12'd4095);

    src_idle_pct = 85;
    snk_idle_pct = 33;
    test_random(55, 12'($urandom_range(0, 64)));

    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_pressure();
    test_random(55, 12'($urandom));
    test_long_messages();

    frm_if.valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (due_results.size() != 0) begin
      report_mismatch("results still due", 0, due_results.size());
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
